// File: hdl/md4skm_pkg.sv
// ----------------------------------------------------------------------------
// md4skm_pkg
// shared types, constants and step functions for the md4 short key matcher
// ----------------------------------------------------------------------------
package md4skm_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] ROUND2_K = 32'h5a827999;
  localparam logic [31:0] ROUND3_K = 32'h6ed9eba1;

  localparam int NUM_STEPS  = 41;
  localparam int LEN_W      = 6;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_A   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_B   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_C   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_D   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 3'd4;

  localparam int R1_SHIFT [4] = '{3, 7, 11, 19};
  localparam int R2_SHIFT [4] = '{3, 5, 9, 13};
  localparam int R3_SHIFT [4] = '{3, 9, 11, 15};
  localparam int R2_WORD [16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};
  localparam int R3_WORD [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};

  typedef logic [3:0][31:0] md4skm_state_t;

  typedef struct packed {
    logic [31:0]   m0;
    logic [31:0]   m1;
    md4skm_state_t v;
  } md4skm_cell_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    logic [31:0] r;
    r = (x << s) | (x >> (32 - s));
    return r;
  endfunction

  function automatic logic [31:0] rotr32_var(input logic [31:0] x, input logic [4:0] s);
    logic [31:0] r;
    r = (x >> s) | (x << (6'd32 - {1'b0, s}));
    return r;
  endfunction

  function automatic logic [31:0] msg_word(input int idx, input logic [31:0] m0,
                                           input logic [31:0] m1,
                                           input logic [LEN_W-1:0] len);
    logic [31:0] w;
    if (idx == 0) begin
      w = m0;
    end else if (idx == 1) begin
      w = m1;
    end else if (idx == 14) begin
      w = {{(32-LEN_W){1'b0}}, len};
    end else begin
      w = '0;
    end
    return w;
  endfunction

  // one forward md4 step, step is a constant per cell
  function automatic md4skm_state_t md4_step(input int step, input md4skm_cell_t c,
                                             input logic [LEN_W-1:0] len);
    md4skm_state_t v;
    int            rnd;
    int            pos;
    logic [1:0]    t;
    logic [31:0]   x;
    logic [31:0]   y;
    logic [31:0]   z;
    logic [31:0]   f;
    logic [31:0]   w;
    int            s;
    v   = c.v;
    rnd = step >> 4;
    pos = step & 15;
    t   = 2'(4 - (step & 3));
    x   = v[t + 2'd1];
    y   = v[t + 2'd2];
    z   = v[t + 2'd3];
    if (rnd == 0) begin
      f = (x & y) | (~x & z);
      w = msg_word(pos, c.m0, c.m1, len);
      s = R1_SHIFT[pos & 3];
    end else if (rnd == 1) begin
      f = (x & y) | (x & z) | (y & z);
      w = msg_word(R2_WORD[pos], c.m0, c.m1, len) + ROUND2_K;
      s = R2_SHIFT[pos & 3];
    end else begin
      f = x ^ y ^ z;
      w = msg_word(R3_WORD[pos], c.m0, c.m1, len) + ROUND3_K;
      s = R3_SHIFT[pos & 3];
    end
    v[t] = rotl32(v[t] + f + w, s);
    return v;
  endfunction

  // one inverse round 3 step with an all-zero message word
  function automatic md4skm_state_t md4_unstep(input md4skm_state_t vin, input logic [3:0] j);
    md4skm_state_t v;
    logic [1:0]    t;
    logic [4:0]    s;
    v = vin;
    t = 2'd0 - j[1:0];
    unique case (j[1:0])
      2'd0:    s = 5'd3;
      2'd1:    s = 5'd9;
      2'd2:    s = 5'd11;
      default: s = 5'd15;
    endcase
    v[t] = rotr32_var(v[t], s) - ((v[t + 2'd1] ^ v[t + 2'd2] ^ v[t + 2'd3]) + ROUND3_K);
    return v;
  endfunction

endpackage

// File: hdl/md4skm_step_cell.sv
// ----------------------------------------------------------------------------
// md4skm_step_cell
// one md4 step with its own stage register, chained into the hash row
// ----------------------------------------------------------------------------
module md4skm_step_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             prev_valid,
  input  md4skm_pkg::md4skm_cell_t         prev_data,
  input  logic [md4skm_pkg::LEN_W-1:0]     key_len,
  output logic                             cell_valid,
  output md4skm_pkg::md4skm_cell_t         cell_data
);
  import md4skm_pkg::*;

  logic         valid_r;
  md4skm_cell_t data_r;
  md4skm_cell_t data_nxt;

  always_comb begin
    data_nxt    = prev_data;
    data_nxt.v  = md4_step(STEP, prev_data, key_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_data  = data_r;

endmodule

// File: hdl/md4skm_target_unwind.sv
// ----------------------------------------------------------------------------
// md4skm_target_unwind
// derives the compare target: digest minus iv, last seven round 3 steps undone
// ----------------------------------------------------------------------------
module md4skm_target_unwind (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  md4skm_pkg::md4skm_state_t digest,
  output logic                      busy,
  output md4skm_pkg::md4skm_state_t rev_target
);
  import md4skm_pkg::*;

  logic          pend_r;
  logic          run_r;
  logic [3:0]    j_r;
  md4skm_state_t v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
      j_r    <= 4'd15;
    end else begin
      if (restart) begin
        pend_r <= 1'b1;
        run_r  <= 1'b0;
      end else if (pend_r) begin
        pend_r <= 1'b0;
        run_r  <= 1'b1;
        j_r    <= 4'd15;
      end else if (run_r) begin
        j_r <= j_r - 4'd1;
        if (j_r == 4'd9) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      v_r[0] <= digest[0] - IV_A;
      v_r[1] <= digest[1] - IV_B;
      v_r[2] <= digest[2] - IV_C;
      v_r[3] <= digest[3] - IV_D;
    end else if (run_r) begin
      v_r <= md4_unstep(v_r, j_r);
    end
  end

  assign busy       = pend_r | run_r;
  assign rev_target = v_r;

endmodule

// File: hdl/md4_short_key_match_top.sv
// ----------------------------------------------------------------------------
// md4_short_key_match_top
// path from an accepted input word to its output word: 41 step cells, one per
//   md4 step, plus the output register
// throughput: one word per cycle, set by the row of step cells, with no output stall or unwind
// reset and every write to a mapped register start a target unwind
//   (load plus seven inverse steps) during which in_tready is low
// ----------------------------------------------------------------------------
module md4_short_key_match_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // message_word_zero, message_word_one
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // is_match, zero fill
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [md4skm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [31:0]                         cfg_data
);
  import md4skm_pkg::*;

  md4skm_state_t    target_r;
  logic [LEN_W-1:0] key_len_r;
  logic             cfg_we;
  logic             unwind_busy;
  md4skm_state_t    rev_target;
  logic             advance;

  logic             cell_valid [NUM_STEPS+1];
  md4skm_cell_t     cell_data  [NUM_STEPS+1];

  logic             out_valid_r;
  logic             match_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      key_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_A:   target_r[0] <= cfg_data;
        REG_TARGET_B:   target_r[1] <= cfg_data;
        REG_TARGET_C:   target_r[2] <= cfg_data;
        REG_TARGET_D:   target_r[3] <= cfg_data;
        REG_KEY_LENGTH: key_len_r   <= cfg_data[LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  md4skm_target_unwind u_unwind (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we && cfg_addr <= REG_KEY_LENGTH),
    .digest     (target_r),
    .busy       (unwind_busy),
    .rev_target (rev_target)
  );

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance && !unwind_busy;

  always_comb begin
    cell_valid[0]   = in_tvalid && !unwind_busy;
    cell_data[0].m0 = in_tdata[31:0];
    cell_data[0].m1 = in_tdata[63:32];
    cell_data[0].v  = {IV_D, IV_C, IV_B, IV_A};
  end

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    md4skm_step_cell #(
      .STEP (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (advance),
      .prev_valid (cell_valid[g]),
      .prev_data  (cell_data[g]),
      .key_len    (key_len_r),
      .cell_valid (cell_valid[g+1]),
      .cell_data  (cell_data[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= cell_valid[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_r <= (cell_data[NUM_STEPS].v == rev_target);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, match_r};

  a_no_accept_while_unwinding: assert property (@(posedge clk) disable iff (!rst_n)
    unwind_busy |-> !in_tready)
    else $error("input accepted while target unwind is running");

  a_cfg_restarts_unwind: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_addr <= REG_KEY_LENGTH) |=> unwind_busy)
    else $error("config write did not restart target unwind");

  a_out_from_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cell_valid[NUM_STEPS]))
    else $error("output word without a word in the last cell");

  a_row_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(cell_valid[NUM_STEPS]))
    else $error("last cell changed while output stalled");

endmodule

// File: dv/md4_short_key_match_checker.sv
// ----------------------------------------------------------------------------
// md4_short_key_match_checker
// watches the config, input and result channels of the md4 short key matcher,
// keeps its own copy of the target registers, unwinds the round 3 tail of the
// target digest, runs the 41 forward md4 steps on every accepted word and
// compares the predicted match flag with each result word in order
// ----------------------------------------------------------------------------
module md4_short_key_match_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [63:0]                       in_tdata,   // message_word_zero, message_word_one
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [7:0]                        out_tdata,  // is_match, zero fill
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [md4skm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                       cfg_data,
  output int                                error_count,
  output int                                results_pending
);
  import md4skm_pkg::*;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam int          FWD_STEPS = 41;

  localparam int STEP_SHIFT [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
  localparam int ROUND2_ORDER [16] = '{0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15};
  localparam int ROUND3_ORDER [16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};

  md4skm_state_t    digest_words;
  logic [LEN_W-1:0] length_bits;
  md4skm_state_t    unwound_target;
  logic             pending_match_flags [$];
  logic             expected_match;

  function automatic logic [31:0] md4_mix(input int rnd, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    if (rnd == 0) begin
      return (x & y) | (~x & z);
    end else if (rnd == 1) begin
      return (x & y) | (x & z) | (y & z);
    end
    return x ^ y ^ z;
  endfunction

  // digest minus iv, then round 3 steps 15 down to 9 taken back
  function automatic md4skm_state_t unwind_round3_tail(input md4skm_state_t digest);
    md4skm_state_t v;
    int            j;
    int            t;
    int            s;
    logic [31:0]   r;
    v[0] = digest[0] - INIT_A;
    v[1] = digest[1] - INIT_B;
    v[2] = digest[2] - INIT_C;
    v[3] = digest[3] - INIT_D;
    for (j = 15; j >= 9; j--) begin
      t    = (4 - (j % 4)) % 4;
      s    = STEP_SHIFT[2][j % 4];
      r    = (v[t] >> s) | (v[t] << (32 - s));
      v[t] = r - (md4_mix(2, v[(t + 1) % 4], v[(t + 2) % 4], v[(t + 3) % 4]) + K_ROUND3);
    end
    return v;
  endfunction

  function automatic logic predict_key_match(input logic [63:0] key_words,
                                             input logic [LEN_W-1:0] len,
                                             input md4skm_state_t goal);
    logic [31:0]   msg [16];
    md4skm_state_t v;
    logic [31:0]   x;
    logic [31:0]   sum;
    int            i;
    int            rnd;
    int            pos;
    int            t;
    int            s;
    foreach (msg[k]) msg[k] = '0;
    msg[0]  = key_words[31:0];
    msg[1]  = key_words[63:32];
    msg[14] = {{(32-LEN_W){1'b0}}, len};
    v = {INIT_D, INIT_C, INIT_B, INIT_A};
    for (i = 0; i < FWD_STEPS; i++) begin
      rnd = i / 16;
      pos = i % 16;
      t   = (4 - (i % 4)) % 4;
      s   = STEP_SHIFT[rnd][i % 4];
      case (rnd)
        0: begin
          x = msg[pos];
        end
        1: begin
          x = msg[ROUND2_ORDER[pos]] + K_ROUND2;
        end
        default: begin
          x = msg[ROUND3_ORDER[pos]] + K_ROUND3;
        end
      endcase
      sum  = v[t] + md4_mix(rnd, v[(t + 1) % 4], v[(t + 2) % 4], v[(t + 3) % 4]) + x;
      v[t] = (sum << s) | (sum >> (32 - s));
    end
    return v == goal;
  endfunction

  initial begin
    error_count     = 0;
    results_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      digest_words   = '0;
      length_bits    = '0;
      unwound_target = unwind_round3_tail('0);
      pending_match_flags.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_TARGET_A:   digest_words[0] = cfg_data;
          REG_TARGET_B:   digest_words[1] = cfg_data;
          REG_TARGET_C:   digest_words[2] = cfg_data;
          REG_TARGET_D:   digest_words[3] = cfg_data;
          REG_KEY_LENGTH: length_bits = cfg_data[LEN_W-1:0];
          default: ;
        endcase
        unwound_target = unwind_round3_tail(digest_words);
      end
      if (out_tvalid && out_tready) begin
        if (pending_match_flags.size() == 0) begin
          $display("%0t: result word %h with no word pending", $time, out_tdata);
          error_count++;
        end else begin
          expected_match = pending_match_flags.pop_front();
          if (out_tdata !== {7'b0, expected_match}) begin
            $display("%0t: is_match mismatch, expected %h, actual %h", $time,
                     {7'b0, expected_match}, out_tdata);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_match_flags.push_back(predict_key_match(in_tdata, length_bits,
                                                        unwound_target));
      end
    end
    results_pending = pending_match_flags.size();
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives md4_short_key_match_top with directed and random candidate keys,
// programs target digests computed here so that matches really occur, and
// varies sender and receiver idling including one long output stall; the
// checker beside the block predicts every match flag
// ----------------------------------------------------------------------------
module testbench;
  import md4skm_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int BATCHES_PER_MODE = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_UNMAPPED = REG_KEY_LENGTH + 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_LAST_UNMAPPED  = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [31:0]           cfg_data;

  int   error_count;
  int   results_pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count = 0;
  logic hold_out = 1'b0;
  event long_hold_ev;

  md4_short_key_match_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  md4_short_key_match_checker key_match_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("md4_short_key_match_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(long_hold_ev);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
  end

  // full md4 of a one block message, used to build reachable targets
  function automatic md4skm_state_t md4_digest(input logic [63:0] key_words,
                                               input logic [LEN_W-1:0] len);
    int            sh [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
    logic [31:0]   m [16];
    md4skm_state_t iv;
    md4skm_state_t v;
    logic [31:0]   x;
    logic [31:0]   y;
    logic [31:0]   z;
    logic [31:0]   f;
    logic [31:0]   k;
    logic [31:0]   sum;
    int            i;
    int            pos;
    int            t;
    int            s;
    int            idx;
    foreach (m[j]) m[j] = '0;
    m[0]  = key_words[31:0];
    m[1]  = key_words[63:32];
    m[14] = {{(32-LEN_W){1'b0}}, len};
    iv = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
    v  = iv;
    for (i = 0; i < 48; i++) begin
      pos = i % 16;
      t   = (4 - (i % 4)) % 4;
      s   = sh[i / 16][i % 4];
      x   = v[(t + 1) % 4];
      y   = v[(t + 2) % 4];
      z   = v[(t + 3) % 4];
      if (i < 16) begin
        f   = (x & y) | (~x & z);
        k   = '0;
        idx = pos;
      end else if (i < 32) begin
        f   = (x & y) | (x & z) | (y & z);
        k   = 32'h5a827999;
        idx = (pos % 4) * 4 + pos / 4;
      end else begin
        f   = x ^ y ^ z;
        k   = 32'h6ed9eba1;
        idx = ((pos & 1) << 3) | ((pos & 2) << 1) | ((pos & 4) >> 1) | ((pos & 8) >> 3);
      end
      sum  = v[t] + f + m[idx] + k;
      v[t] = (sum << s) | (sum >> (32 - s));
    end
    for (i = 0; i < 4; i++) v[i] = v[i] + iv[i];
    return v;
  endfunction

  // key of n bytes with the pad byte right after it
  function automatic logic [63:0] padded_key(input int n);
    logic [63:0] k;
    int          b;
    k = '0;
    for (b = 0; b < n; b++) k[8*b +: 8] = 8'($urandom);
    k[8*n +: 8] = 8'h80;
    return k;
  endfunction

  task automatic send_word(input logic [63:0] words);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= words;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_target(input md4skm_state_t digest, input logic [LEN_W-1:0] len);
    logic [31:0] len_word;
    wait_drained();
    len_word = $urandom;
    len_word[LEN_W-1:0] = len;
    write_reg(REG_TARGET_A, digest[0]);
    write_reg(REG_TARGET_B, digest[1]);
    write_reg(REG_TARGET_C, digest[2]);
    write_reg(REG_TARGET_D, digest[3]);
    write_reg(REG_KEY_LENGTH, len_word);
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_ADDR_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed keys, the stored key itself, near misses and noise
  task automatic send_batch(input logic [63:0] key_words, input int count);
    int n;
    int sel;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        send_word(key_words);
      end else if (sel < 70) begin
        send_word(padded_key($urandom_range(7)));
      end else if (sel < 80) begin
        send_word(key_words ^ (64'd1 << $urandom_range(63)));
      end else begin
        send_word({$urandom, $urandom});
      end
    end
  endtask

  initial begin
    md4skm_state_t    digest;
    logic [63:0]      key_words;
    logic [LEN_W-1:0] len;
    int               mode;
    int               batch;
    int               kind;
    int               nbytes;
    int               j;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero target after reset
    send_word(64'h0);
    send_word('1);
    send_word(64'h80);

    // three byte key and its near misses
    key_words = 64'h0000_0000_8063_6261;
    program_target(md4_digest(key_words, 6'd24), 6'd24);
    send_word(key_words);
    send_word(key_words ^ 64'd1);
    send_word(key_words ^ (64'd1 << 63));
    send_word(key_words);

    // longest key, pad in the top byte
    key_words = 64'h8066_5544_3322_1100;
    program_target(md4_digest(key_words, 6'd56), 6'd56);
    send_word(key_words);
    send_word(key_words ^ (64'd1 << 55));

    // no pad and a length above 56
    key_words = 64'hdead_beef_1234_5678;
    program_target(md4_digest(key_words, 6'd63), 6'd63);
    send_word(key_words);
    send_word(64'h0000_0000_1234_5678);

    // empty key, then writes to unmapped indexes must change nothing
    key_words = 64'h80;
    program_target(md4_digest(key_words, 6'd0), 6'd0);
    send_word(key_words);
    wait_drained();
    write_reg(REG_FIRST_UNMAPPED, $urandom);
    write_reg(REG_LAST_UNMAPPED, '1);
    cfg_valid <= 1'b0;
    send_word(key_words);
    send_word(64'h0);

    // all-ones target
    program_target('1, 6'd56);
    send_word({$urandom, $urandom});
    send_word(padded_key(7));

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 68 : 0;
      recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 6 : 0;
      for (batch = 0; batch < BATCHES_PER_MODE; batch++) begin
        kind   = $urandom_range(9);
        nbytes = $urandom_range(7);
        key_words = padded_key(nbytes);
        if (kind == 0) begin
          for (j = 0; j < 4; j++) begin
            if ($urandom_range(3) == 0) begin
              digest[j] = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
            end else begin
              digest[j] = $urandom;
            end
          end
          len = LEN_W'($urandom_range(63));
        end else begin
          len    = (kind == 1) ? LEN_W'($urandom_range(63)) : LEN_W'(8 * nbytes);
          digest = md4_digest(key_words, len);
        end
        program_target(digest, len);
        if (mode == 2 && batch == 0) begin
          -> long_hold_ev;
          send_batch(key_words, 150);
        end else begin
          send_batch(key_words, $urandom_range(40, 80));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("md4_short_key_match_top verification clean");
    end else begin
      $display("md4_short_key_match_top verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/md4skm_pkg.sv
hdl/md4skm_step_cell.sv
hdl/md4skm_target_unwind.sv
hdl/md4_short_key_match_top.sv
dv/md4_short_key_match_checker.sv
dv/testbench.sv
